FILE: rtl/core/sbpr_pkg.sv
// Shared types and constants for the servo bus packet receiver.
`default_nettype none
package sbpr_pkg;

  localparam logic [7:0] SYNC_BYTE = 8'hFF;
  localparam logic [7:0] SUM_GOOD  = 8'hFF;
  localparam int         IDX_W     = 6;

  typedef enum logic [2:0] {
    PH_HDR1,
    PH_HDR2,
    PH_ID,
    PH_LEN,
    PH_BODY
  } phase_t;

  typedef enum logic {
    RP_IDLE,
    RP_SHOW
  } rp_state_t;

  typedef struct packed {
    logic             valid;
    logic [7:0]       id;
    logic [7:0]       length;
    logic [IDX_W-1:0] last_idx;
  } start_t;

endpackage
`default_nettype wire

FILE: rtl/core/sbpr_if.sv
// Valid/ready channel interfaces for received bytes and replayed frame words.
`default_nettype none
interface sbpr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sbpr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_id;
  logic [7:0] frame_length;
  logic [5:0] byte_index;
  logic [7:0] body_byte;
  logic       last;

  modport source (output valid, output frame_id, output frame_length, output byte_index,
                  output body_byte, output last, input ready);
  modport sink   (input valid, input frame_id, input frame_length, input byte_index,
                  input body_byte, input last, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/servo_bus_packet_receiver.sv
// Top level of the servo bus packet receiver.
// Takes one received byte per cycle while in_ch.ready is high and parses 0xFF 0xFF,
// id, length, body frames into a body RAM. When a frame ends with a good checksum
// and fits the RAM, its body is replayed on the output channel one word per cycle
// while out_ch.ready is high, each word carrying id, length, body index and byte,
// with last set on the checksum byte. The input is held off (in_ch.ready low) from
// the edge that takes the final body byte until the last word of that frame is
// taken, so an accepted frame blocks the input for the whole of its replay, output
// stalls included; the single read port of the body RAM paces the replay. The first
// replay read can hit the entry that is written at the same edge, so that byte is
// forwarded around the RAM. Bad frames produce no words and never block. The RAM
// needs no clearing after reset.
`default_nettype none
module servo_bus_packet_receiver #(
  parameter int BODY_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  sbpr_in_if.sink     in_ch,
  sbpr_out_if.source  out_ch
);
  import sbpr_pkg::*;

  localparam int AW = $clog2(BODY_DEPTH);

  start_t        start;
  logic          busy;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  logic [7:0]    ram_q;
  logic          fwd_r;
  logic [7:0]    fwd_byte_r;

  sbpr_parser #(
    .BODY_DEPTH (BODY_DEPTH),
    .AW         (AW)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .busy    (busy),
    .start   (start),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  sbpr_ram #(
    .WIDTH (8),
    .DEPTH (BODY_DEPTH),
    .AW    (AW)
  ) u_body_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  // forward a byte written at the same edge as its read; hold with the read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (rd_en) begin
      fwd_r <= wr_en && (wr_addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_byte_r <= wr_data;
    end
  end

  assign rd_data = fwd_r ? fwd_byte_r : ram_q;

  sbpr_replay #(
    .BODY_DEPTH (BODY_DEPTH),
    .AW         (AW)
  ) u_replay (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .out_ch  (out_ch)
  );

endmodule
`default_nettype wire

FILE: rtl/core/sbpr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sbpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/sbpr_parser.sv
// Frame parser: header search, checksum, body write into the RAM.
`default_nettype none
module sbpr_parser #(
  parameter int BODY_DEPTH = 64,
  parameter int AW         = $clog2(BODY_DEPTH)
) (
  input  logic            clk,
  input  logic            rst_n,
  sbpr_in_if.sink         in_ch,
  input  logic            busy,
  output sbpr_pkg::start_t start,
  output logic            wr_en,
  output logic [AW-1:0]   wr_addr,
  output logic [7:0]      wr_data
);
  import sbpr_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [7:0] id_r, id_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic [7:0] sum_r, sum_nxt;

  logic       accept;
  logic [7:0] cnt_inc;
  logic [7:0] sum_add;
  logic       frame_done;
  logic [7:0] rx;

  assign in_ch.ready = !busy;
  assign accept      = in_ch.valid && in_ch.ready;
  assign rx          = in_ch.rx_byte;
  assign cnt_inc     = (cnt_r == 8'hFF) ? cnt_r : cnt_r + 8'd1;
  assign sum_add     = sum_r + rx;
  assign frame_done  = cnt_inc >= len_r;

  assign wr_addr = cnt_r[AW-1:0];
  assign wr_data = rx;

  always_comb begin
    phase_nxt = phase_r;
    if (accept) begin
      case (phase_r)
        PH_HDR2: phase_nxt = (rx == SYNC_BYTE) ? PH_ID : PH_HDR1;
        PH_ID:   phase_nxt = PH_LEN;
        PH_LEN:  phase_nxt = PH_BODY;
        PH_BODY: phase_nxt = frame_done ? PH_HDR1 : PH_BODY;
        default: phase_nxt = (rx == SYNC_BYTE) ? PH_HDR2 : PH_HDR1;
      endcase
    end
  end

  always_comb begin
    id_nxt         = id_r;
    len_nxt        = len_r;
    cnt_nxt        = cnt_r;
    sum_nxt        = sum_r;
    wr_en          = 1'b0;
    start.valid    = 1'b0;
    start.id       = id_r;
    start.length   = len_r;
    start.last_idx = IDX_W'(cnt_inc - 8'd1);
    if (accept) begin
      case (phase_r)
        PH_ID: begin
          id_nxt  = rx;
          sum_nxt = rx;
        end
        PH_LEN: begin
          len_nxt = rx;
          cnt_nxt = 8'd0;
          sum_nxt = sum_add;
        end
        PH_BODY: begin
          // bytes past the store still count toward the sum
          wr_en       = cnt_r < 8'(BODY_DEPTH);
          sum_nxt     = sum_add;
          cnt_nxt     = cnt_inc;
          start.valid = frame_done && (sum_add == SUM_GOOD) && (cnt_inc < 8'(BODY_DEPTH));
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR1;
      id_r    <= 8'd0;
      len_r   <= 8'd0;
      cnt_r   <= 8'd0;
      sum_r   <= 8'd0;
    end else begin
      phase_r <= phase_nxt;
      id_r    <= id_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      sum_r   <= sum_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/sbpr_replay.sv
// Replay engine: reads an accepted body back from the RAM, one word per cycle while the output is ready.
`default_nettype none
module sbpr_replay #(
  parameter int BODY_DEPTH = 64,
  parameter int AW         = $clog2(BODY_DEPTH)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  sbpr_pkg::start_t start,
  output logic             busy,
  output logic             rd_en,
  output logic [AW-1:0]    rd_addr,
  input  logic [7:0]       rd_data,
  sbpr_out_if.source       out_ch
);
  import sbpr_pkg::*;

  rp_state_t     state_r, state_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [AW-1:0] last_r;
  logic [7:0]    id_r;
  logic [7:0]    len_r;

  logic          take;
  logic          is_last;
  logic [AW-1:0] idx_inc;

  assign take    = out_ch.valid && out_ch.ready;
  assign is_last = idx_r == last_r;
  assign idx_inc = AW'(idx_r + 1'b1);
  assign busy    = state_r == RP_SHOW;

  assign out_ch.valid        = state_r == RP_SHOW;
  assign out_ch.frame_id     = id_r;
  assign out_ch.frame_length = len_r;
  assign out_ch.byte_index   = IDX_W'(idx_r);
  assign out_ch.body_byte    = rd_data;
  assign out_ch.last         = is_last;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      RP_IDLE: if (start.valid) state_nxt = RP_SHOW;
      RP_SHOW: if (take && is_last) state_nxt = RP_IDLE;
      default: state_nxt = RP_IDLE;
    endcase
  end

  // read ahead so the next body byte lands as the current word is taken
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx_inc;
    idx_nxt = idx_r;
    case (state_r)
      RP_IDLE: begin
        if (start.valid) begin
          rd_en   = 1'b1;
          rd_addr = '0;
          idx_nxt = '0;
        end
      end
      RP_SHOW: begin
        if (take && !is_last) begin
          rd_en   = 1'b1;
          idx_nxt = idx_inc;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= RP_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == RP_IDLE && start.valid) begin
      id_r   <= start.id;
      len_r  <= start.length;
      last_r <= start.last_idx[AW-1:0];
    end
  end

`ifndef SYNTHESIS
  a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start.valid |-> state_r == RP_IDLE)
    else $error("frame start while replay busy");

  a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    take && out_ch.last |=> !out_ch.valid)
    else $error("word shown after last of frame");

  a_index_steps: assert property (@(posedge clk) disable iff (!rst_n)
    take && !out_ch.last |=> out_ch.byte_index == $past(out_ch.byte_index) + 6'd1)
    else $error("body index did not advance by one");
`endif

endmodule
`default_nettype wire

FILE: bench/tb_servo_bus_packet_receiver.sv
// Testbench for the servo bus packet receiver: directed and random byte streams, checked word by word.
module tb_servo_bus_packet_receiver;
  import sbpr_pkg::*;

  localparam int BODY_DEPTH  = 64;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 40;
  localparam int SHOW_MAX    = 10;

  typedef struct packed {
    logic [7:0]       id;
    logic [7:0]       length;
    logic [IDX_W-1:0] index;
    logic [7:0]       body;
    logic             last;
  } frame_word_t;

  logic clk = 1'b0;
  logic rst_n;

  sbpr_in_if  in_if();
  sbpr_out_if out_if();

  servo_bus_packet_receiver #(.BODY_DEPTH(BODY_DEPTH)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  always #5 clk = ~clk;

  // Parser mirror: frame state and body memory.
  phase_t     rx_phase = PH_HDR1;
  logic [7:0] cur_id   = 8'h00;
  logic [7:0] cur_len  = 8'h00;
  logic [7:0] body_cnt = 8'h00;
  logic [7:0] run_sum  = 8'h00;
  logic [7:0] body_mem [BODY_DEPTH];

  frame_word_t pending_words[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_request  = 0;
  int bytes_sent    = 0;
  int mismatch_count = 0;
  int cycle_count   = 0;

  function automatic void parse_rx_byte(input logic [7:0] c);
    frame_word_t w;
    case (rx_phase)
      PH_HDR2: rx_phase = (c == SYNC_BYTE) ? PH_ID : PH_HDR1;
      PH_ID: begin
        cur_id   = c;
        run_sum  = c;
        rx_phase = PH_LEN;
      end
      PH_LEN: begin
        cur_len  = c;
        body_cnt = 8'h00;
        run_sum  = run_sum + c;
        rx_phase = PH_BODY;
      end
      PH_BODY: begin
        if (body_cnt < BODY_DEPTH) body_mem[body_cnt[5:0]] = c;
        run_sum = run_sum + c;
        if (body_cnt != 8'hFF) body_cnt = body_cnt + 8'd1;
        // A zero length still takes one byte, so compare after the increment.
        if (body_cnt >= cur_len) begin
          if (run_sum == SUM_GOOD && body_cnt < BODY_DEPTH) begin
            for (int k = 0; k < body_cnt; k++) begin
              w.id     = cur_id;
              w.length = cur_len;
              w.index  = k[IDX_W-1:0];
              w.body   = body_mem[k];
              w.last   = (k + 1 == body_cnt);
              pending_words.push_back(w);
            end
          end
          rx_phase = PH_HDR1;
        end
      end
      default: rx_phase = (c == SYNC_BYTE) ? PH_HDR2 : PH_HDR1;
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready) parse_rx_byte(in_if.rx_byte);
  end

  always @(posedge clk) begin
    frame_word_t got;
    frame_word_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.id     = out_if.frame_id;
      got.length = out_if.frame_length;
      got.index  = out_if.byte_index;
      got.body   = out_if.body_byte;
      got.last   = out_if.last;
      if (pending_words.size() == 0) begin
        if (mismatch_count < SHOW_MAX)
          $display("unexpected word: id=%02h len=%02h idx=%0d byte=%02h last=%b",
                   got.id, got.length, got.index, got.body, got.last);
        mismatch_count++;
      end else begin
        want = pending_words.pop_front();
        if (got.id !== want.id || got.length !== want.length || got.index !== want.index ||
            got.body !== want.body || got.last !== want.last) begin
          if (mismatch_count < SHOW_MAX) begin
            $display("word mismatch: exp id=%02h len=%02h idx=%0d byte=%02h last=%b",
                     want.id, want.length, want.index, want.body, want.last);
            $display("               got id=%02h len=%02h idx=%0d byte=%02h last=%b",
                     got.id, got.length, got.index, got.body, got.last);
          end
          mismatch_count++;
        end
      end
    end
  end

  // Result side: random stalls, plus a long hold when one is requested.
  initial begin
    int hold_left;
    hold_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_rx_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.rx_byte <= b;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    bytes_sent++;
  endtask

  // Send sync, id, length and body; the last body byte is the checksum.
  task automatic send_frame(input logic [7:0] id, input logic [7:0] len, input bit good);
    logic [7:0] sum;
    logic [7:0] b;
    int n;
    send_rx_byte(SYNC_BYTE);
    send_rx_byte(SYNC_BYTE);
    send_rx_byte(id);
    send_rx_byte(len);
    sum = id + len;
    n = (len == 8'd0) ? 1 : int'(len);
    for (int k = 0; k < n - 1; k++) begin
      b = 8'($urandom_range(0, 255));
      sum = sum + b;
      send_rx_byte(b);
    end
    b = SUM_GOOD - sum;
    if (!good) b = b ^ 8'($urandom_range(1, 255));
    send_rx_byte(b);
  endtask

  function automatic logic [7:0] rand_len();
    return ($urandom_range(9) < 8) ? 8'($urandom_range(0, 8)) : 8'($urandom_range(9, 63));
  endfunction

  task automatic test_header_and_short_frames();
    send_rx_byte(8'h00);
    // broken sync: second byte not 0xFF
    send_rx_byte(SYNC_BYTE);
    send_rx_byte(8'h00);
    send_rx_byte(SYNC_BYTE);
    send_rx_byte(8'h7F);
    send_frame(8'h01, 8'd0, 1'b1);
    send_frame(8'h02, 8'd0, 1'b0);
    send_frame(8'h00, 8'd1, 1'b1);
    send_frame(8'hFF, 8'd2, 1'b1);
    send_frame(8'h80, 8'd3, 1'b0);
  endtask

  task automatic test_long_frames();
    send_frame(8'h55, 8'd63, 1'b1);
    // good sum but no room in the body store: drop
    send_frame(8'hAA, 8'd64, 1'b1);
    send_frame(8'h0F, 8'd5, 1'b1);
  endtask

  task automatic test_random_traffic(input int snd_idle, input int rcv_idle, input int n_bytes);
    int stop_at;
    int pick;
    send_idle_pct = snd_idle;
    recv_idle_pct = rcv_idle;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        send_frame(8'($urandom_range(0, 255)), rand_len(), 1'b1);
      end else if (pick < 80) begin
        send_frame(8'($urandom_range(0, 255)), rand_len(), 1'b0);
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 4)) send_rx_byte(8'($urandom_range(0, 255)));
      end else begin
        send_rx_byte(SYNC_BYTE);
        send_rx_byte(8'($urandom_range(0, 254)));
      end
    end
  endtask

  // Hold the result side while frames keep coming, so the input backs up.
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request  = 300;
    send_frame(8'h21, 8'd12, 1'b1);
    send_frame(8'h22, 8'd12, 1'b1);
    send_frame(8'h23, 8'd4, 1'b1);
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_if.valid   <= 1'b0;
    in_if.rx_byte <= 8'h00;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 35;
    recv_idle_pct = 52;
    test_header_and_short_frames();
    test_long_frames();
    test_random_traffic(35, 52, 15);
    test_random_traffic(52, 35, 15);
    test_output_backpressure();
    test_random_traffic(0, 0, 15);

    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (pending_words.size() != 0) begin
      $display("missing words: %0d still expected", pending_words.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/sbpr_pkg.sv
rtl/core/sbpr_if.sv
rtl/core/sbpr_ram.sv
rtl/core/sbpr_parser.sv
rtl/core/sbpr_replay.sv
rtl/core/servo_bus_packet_receiver.sv
bench/tb_servo_bus_packet_receiver.sv
